// ===== rtl/frpt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// frpt_pkg
// Shared types, codes and helpers for the FASTQ record parser/trimmer.
// ============================================================================
package frpt_pkg;

    // Width of the per-line saturating counters.
    localparam int COUNT_BITS = 16;
    localparam int INDEX_BITS = 16;
    localparam int TRIM_BITS  = 16;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [2:0] {
        PH_HDR_START = 3'd0,
        PH_HDR       = 3'd1,
        PH_SEQ       = 3'd2,
        PH_SEP_START = 3'd3,
        PH_SEP       = 3'd4,
        PH_QUAL      = 3'd5,
        PH_HALT      = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ID_BEFORE = 2'd0,
        ID_IN     = 2'd1,
        ID_AFTER  = 2'd2
    } t_id_phase;

    typedef enum logic [2:0] {
        K_HDR    = 3'd0,
        K_BASE   = 3'd1,
        K_QUAL   = 3'd2,
        K_DONE   = 3'd3,
        K_STOP   = 3'd4,
        K_BADHDR = 3'd5,
        K_BADSEP = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        t_kind                 out_kind;
        logic [7:0]            out_byte;
        logic                  in_id;
        logic [INDEX_BITS-1:0] out_index;
        logic                  out_last;
    } t_out_item;

    function automatic t_count sat_inc(input t_count c);
        return (c == {COUNT_BITS{1'b1}}) ? c : c + t_count'(1);
    endfunction

    function automatic logic [INDEX_BITS-1:0] to_index(input t_count c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'(16'hFFFF)) ? {INDEX_BITS{1'b1}} : w[INDEX_BITS-1:0];
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR);
    endfunction

    function automatic t_out_item mk_item(input t_kind k, input logic [7:0] b,
                                          input logic id,
                                          input logic [INDEX_BITS-1:0] idx,
                                          input logic last);
        t_out_item r;
        r.out_kind  = k;
        r.out_byte  = b;
        r.in_id     = id;
        r.out_index = idx;
        r.out_last  = last;
        return r;
    endfunction

endpackage

// ===== rtl/fastq_record_parser_trim_core.sv =====
// Path: an accepted byte passes the input register, then parse logic into
//   a 3-entry result queue, from whose head its result is offered.
// Throughput: one byte per cycle; a step yields at most two results, and the
//   input stalls only while the result queue holds two or more items.
// Reset: synchronous, active-low i_rst_n; clears parser state, trim_length
//   and the queue. No clearing pass, the block is ready the cycle after.
`timescale 1ns / 1ps
// ============================================================================
// fastq_record_parser_trim_core
// Byte-serial FASTQ parser: tags header/id bytes, bases and qualities,
// trims to trim_length, and reports record done, clean stop and errors.
// ============================================================================
module fastq_record_parser_trim_core
    import frpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // result output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // trim_length write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TRIM_BITS-1:0] i_cfg_data
);

    localparam int QDEPTH = 3;

    // ------------------------------------------------------------------
    // Configuration: always ready; writes must arrive only while idle (not enforced here).
    // ------------------------------------------------------------------
    logic [TRIM_BITS-1:0] r_trim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_trim <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic     r_in_vld;
    t_in_item r_in;
    logic     w_adv;    // queue has room for a two-result step
    logic     w_go;     // parse the registered byte this cycle
    logic [1:0] r_cnt;

    assign w_adv      = (r_cnt <= 2'd1);
    assign w_go       = r_in_vld && w_adv;
    assign o_in_stall = r_in_vld && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_phase    r_phase, n_phase;
    t_id_phase r_id, n_id;
    t_count    r_seq, n_seq;
    t_count    r_qual, n_qual;
    t_count    r_hdr, n_hdr;

    t_out_item w_res0, w_res1;
    logic [1:0] w_nres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_START;
            r_id    <= ID_BEFORE;
            r_seq   <= '0;
            r_qual  <= '0;
            r_hdr   <= '0;
        end else if (w_go) begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_seq   <= n_seq;
            r_qual  <= n_qual;
            r_hdr   <= n_hdr;
        end
    end

    // One byte per step: next state plus up to two results.
    always_comb begin
        logic [7:0]  b;
        logic        fin;
        logic [31:0] seq_w;
        logic [31:0] qual_w;
        logic [31:0] trim_w;
        logic        trimmed;

        b       = r_in.data_byte;
        fin     = r_in.is_end;
        seq_w   = 32'(r_seq);
        qual_w  = 32'(r_qual);
        trim_w  = 32'(r_trim);
        trimmed = (r_trim != '0) && (seq_w > trim_w);

        n_phase = r_phase;
        n_id    = r_id;
        n_seq   = r_seq;
        n_qual  = r_qual;
        n_hdr   = r_hdr;
        w_nres  = 2'd0;
        w_res0  = mk_item(K_STOP, 8'h00, 1'b0, '0, 1'b1);
        w_res1  = mk_item(K_STOP, 8'h00, 1'b0, '0, 1'b1);

        case (r_phase)
            PH_HDR_START: begin
                if (fin || b == CH_LF || b == CH_CR) begin
                    // empty line or end of input: clean stop
                    w_nres  = 2'd1;
                    n_phase = PH_HALT;
                end else if (b == CH_AT) begin
                    n_seq   = '0;
                    n_qual  = '0;
                    n_hdr   = '0;
                    n_id    = ID_BEFORE;
                    n_phase = PH_HDR;
                end else begin
                    w_res0  = mk_item(K_BADHDR, 8'h00, 1'b0, '0, 1'b1);
                    w_nres  = 2'd1;
                    n_phase = PH_HALT;
                end
            end
            PH_HDR: begin
                if (fin) begin
                    w_res0  = mk_item(K_BADSEP, 8'h00, 1'b0, '0, 1'b1);
                    w_nres  = 2'd1;
                    n_phase = PH_HALT;
                end else if (b == CH_LF) begin
                    n_phase = PH_SEQ;
                end else begin
                    // id token: first run of non-whitespace
                    if (r_id == ID_BEFORE && !is_ws(b)) begin
                        n_id = ID_IN;
                    end else if (r_id == ID_IN && is_ws(b)) begin
                        n_id = ID_AFTER;
                    end
                    w_res0 = mk_item(K_HDR, b, n_id == ID_IN, to_index(r_hdr), 1'b1);
                    w_nres = 2'd1;
                    n_hdr  = sat_inc(r_hdr);
                end
            end
            PH_SEQ: begin
                if (fin) begin
                    w_res0  = mk_item(K_BADSEP, 8'h00, 1'b0, '0, 1'b1);
                    w_nres  = 2'd1;
                    n_phase = PH_HALT;
                end else if (b == CH_LF) begin
                    n_phase = PH_SEP_START;
                end else begin
                    if (r_trim == '0 || seq_w < trim_w) begin
                        w_res0 = mk_item(K_BASE, b, 1'b0, to_index(r_seq), 1'b1);
                        w_nres = 2'd1;
                    end
                    n_seq = sat_inc(r_seq);
                end
            end
            PH_SEP_START: begin
                if (!fin && b == CH_PLUS) begin
                    n_phase = PH_SEP;
                end else if (!fin && b == CH_CR) begin
                    w_nres  = 2'd1;
                    n_phase = PH_HALT;
                end else begin
                    w_res0  = mk_item(K_BADSEP, 8'h00, 1'b0, '0, 1'b1);
                    w_nres  = 2'd1;
                    n_phase = PH_HALT;
                end
            end
            PH_SEP: begin
                if (fin) begin
                    w_res0  = mk_item(K_DONE, 8'h00, 1'b0, '0, 1'b0);
                    w_nres  = 2'd2;
                    n_phase = PH_HALT;
                end else if (b == CH_LF) begin
                    n_qual  = '0;
                    n_phase = PH_QUAL;
                end
            end
            PH_QUAL: begin
                if (fin) begin
                    w_res0  = mk_item(K_DONE, 8'h00, 1'b0, '0, 1'b0);
                    w_nres  = 2'd2;
                    n_phase = PH_HALT;
                end else if (b == CH_LF) begin
                    w_res0  = mk_item(K_DONE, 8'h00, 1'b0, '0, 1'b1);
                    w_nres  = 2'd1;
                    n_seq   = '0;
                    n_qual  = '0;
                    n_hdr   = '0;
                    n_id    = ID_BEFORE;
                    n_phase = PH_HDR_START;
                end else begin
                    // qualities are cut only when the sequence ran past the limit
                    if (!trimmed || qual_w < trim_w) begin
                        w_res0 = mk_item(K_QUAL, b, 1'b0, to_index(r_qual), 1'b1);
                        w_nres = 2'd1;
                    end
                    n_qual = sat_inc(r_qual);
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result queue: shift register, head in slot 0.
    // ------------------------------------------------------------------
    t_out_item r_q [QDEPTH];
    t_out_item n_q [QDEPTH];
    logic [1:0] n_cnt;
    logic       w_pop;

    assign w_pop       = (r_cnt != 2'd0) && !i_out_stall;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_q[0];

    always_comb begin
        logic [1:0] base;
        base = r_cnt - {1'b0, w_pop};
        for (int j = 0; j < QDEPTH; j++) begin
            if (w_pop && j < QDEPTH - 1) begin
                n_q[j] = r_q[j+1];
            end else begin
                n_q[j] = r_q[j];
            end
            if (w_go && w_nres != 2'd0 && 2'(j) == base) begin
                n_q[j] = w_res0;
            end
            if (w_go && w_nres == 2'd2 && 2'(j) == base + 2'd1) begin
                n_q[j] = w_res1;
            end
        end
        n_cnt = base + (w_go ? w_nres : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QDEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

endmodule

// ===== rtl/frpt_chk.sv =====
`timescale 1ns / 1ps
// ============================================================================
// frpt_chk
// Port-level checks for the FASTQ parser, bound to the top level.
// ============================================================================
module frpt_chk
    import frpt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_item
);

    // stalled result holds until transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // stop and error results close their step
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.out_kind == K_STOP ||
                         o_out_item.out_kind == K_BADHDR ||
                         o_out_item.out_kind == K_BADSEP)) |-> o_out_item.out_last)
        else $error("terminal result not marked last");

    // only header/base/quality carry data; id tag only on header bytes
    a_ctrl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.out_kind != K_HDR) |->
            (!o_out_item.in_id &&
             ((o_out_item.out_kind == K_BASE || o_out_item.out_kind == K_QUAL) ||
              (o_out_item.out_byte == 8'h00 && o_out_item.out_index == '0))))
        else $error("control result carries data");

endmodule

bind fastq_record_parser_trim_core frpt_chk u_frpt_chk (.*);
